[rtl/hamming_sec_codec_macros.svh]
// assertion macros used by the codec checker
`ifndef HAMMING_SEC_CODEC_MACROS_SVH
`define HAMMING_SEC_CODEC_MACROS_SVH

// clocked property with reset disable
`define HSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that must hold whenever the result channel shows an item
`define HSC_ASSERT_RSP(lbl, clk, rst, vld, prop, msg) \
   `HSC_ASSERT(lbl, clk, rst, (vld |-> (prop)), msg)

`endif

[rtl/hsc_pkg.sv]
// types, codes and bit mapping functions of the hamming codec
package hsc_pkg;

   localparam int MAX_DATA_BITS = 57;
   localparam int DATA_W        = 57;
   localparam int CODE_W        = 63;
   localparam int LEN_W         = 6;

   localparam logic       CMD_ENCODE = 1'b0;
   localparam logic       CMD_DECODE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CORRECTED = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [DATA_W-1:0] data_in;
      logic [CODE_W-1:0] codeword_in;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] codeword_out;
      logic [LEN_W-1:0]  code_length;
      logic [LEN_W-1:0]  syndrome;
      logic [1:0]        status;
      logic [DATA_W-1:0] data_out;
   } rsp_type;

   // after the front stage: masked word laid out by position
   typedef struct packed {
      logic              cmd;
      logic [LEN_W-1:0]  n;
      logic [CODE_W-1:0] word;
   } s1_type;

   // after the parity trees
   typedef struct packed {
      logic              cmd;
      logic [LEN_W-1:0]  n;
      logic [CODE_W-1:0] word;
      logic [LEN_W-1:0]  syn;
   } s2_type;

   // code length n = k + r, r smallest with 2^r >= k + r + 1
   function automatic logic [LEN_W-1:0] code_len(input logic [LEN_W-1:0] k);
      int par;
      par = LEN_W;
      for (int i = LEN_W; i >= 1; i--) begin
         if ((1 << i) >= int'(k) + i + 1) par = i;
      end
      return LEN_W'(int'(k) + par);
   endfunction

   // data bit j goes to the j-th position that is not a power of two
   function automatic logic [CODE_W-1:0] scatter_data(input logic [DATA_W-1:0] d);
      logic [CODE_W-1:0] w;
      int                j;
      w = '0;
      j = 0;
      for (int p = 1; p <= CODE_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            w[p-1] = d[j];
            j++;
         end
      end
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] gather_data(input logic [CODE_W-1:0] w);
      logic [DATA_W-1:0] d;
      int                j;
      d = '0;
      j = 0;
      for (int p = 1; p <= CODE_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            d[j] = w[p-1];
            j++;
         end
      end
      return d;
   endfunction

   // positions whose index has bit m set
   function automatic logic [CODE_W-1:0] pos_mask(input int m);
      logic [CODE_W-1:0] w;
      for (int p = 1; p <= CODE_W; p++) begin
         w[p-1] = ((p >> m) & 1) != 0;
      end
      return w;
   endfunction

endpackage

[rtl/hsc_front.sv]
// first stage: length from data_bits, masking and data placement
module hsc_front
   import hsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  req_type          in_req,
   input  logic [LEN_W-1:0] data_bits,
   output logic             out_valid,
   output s1_type           out_s1
);

   logic             valid_ff;
   s1_type           s1_ff;
   s1_type           s1_in;
   logic [LEN_W-1:0] k_eff;
   logic [LEN_W-1:0] n_len;
   logic [DATA_W-1:0] mask_k;
   logic [CODE_W-1:0] mask_n;

   // saturate k to 1..MAX_DATA_BITS
   always_comb begin
      priority if (data_bits == '0) begin
         k_eff = LEN_W'(1);
      end else if (data_bits > LEN_W'(MAX_DATA_BITS)) begin
         k_eff = LEN_W'(MAX_DATA_BITS);
      end else begin
         k_eff = data_bits;
      end
   end

   assign n_len = code_len(k_eff);

   always_comb begin
      for (int i = 0; i < DATA_W; i++) mask_k[i] = (i < int'(k_eff));
      for (int i = 0; i < CODE_W; i++) mask_n[i] = (i < int'(n_len));
   end

   always_comb begin
      s1_in.cmd = in_req.cmd;
      s1_in.n   = n_len;
      if (in_req.cmd == CMD_DECODE) begin
         s1_in.word = in_req.codeword_in & mask_n;
      end else begin
         s1_in.word = scatter_data(in_req.data_in & mask_k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         s1_ff <= s1_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_s1    = s1_ff;

endmodule

[rtl/hsc_syndrome.sv]
// second stage: parity trees giving the position xor of all set bits
module hsc_syndrome
   import hsc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   adv,
   input  logic   in_valid,
   input  s1_type in_s1,
   output logic   out_valid,
   output s2_type out_s2
);

   logic             valid_ff;
   s2_type           s2_ff;
   logic [LEN_W-1:0] syn_in;

   always_comb begin
      for (int m = 0; m < LEN_W; m++) begin
         syn_in[m] = ^(in_s1.word & pos_mask(m));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         s2_ff.cmd  <= in_s1.cmd;
         s2_ff.n    <= in_s1.n;
         s2_ff.word <= in_s1.word;
         s2_ff.syn  <= syn_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_s2    = s2_ff;

endmodule

[rtl/hsc_back.sv]
// third stage: parity insert or correction, data extraction, result register
module hsc_back
   import hsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_valid,
   input  s2_type  in_s2,
   output logic    out_valid,
   output rsp_type out_rsp
);

   logic              valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic [CODE_W-1:0] cw;
   logic [CODE_W-1:0] par_bits;

   always_comb begin
      par_bits = '0;
      for (int m = 0; m < LEN_W; m++) begin
         par_bits[(1 << m) - 1] = in_s2.syn[m];
      end
   end

   always_comb begin
      cw            = in_s2.word;
      rsp_in.status = STATUS_OK;
      if (in_s2.cmd == CMD_ENCODE) begin
         cw = in_s2.word | par_bits;
      end else if (in_s2.syn != '0) begin
         if (in_s2.syn <= in_s2.n) begin
            cw            = in_s2.word ^ (CODE_W'(1) << (in_s2.syn - LEN_W'(1)));
            rsp_in.status = STATUS_CORRECTED;
         end else begin
            rsp_in.status = STATUS_RANGE;
         end
      end
      rsp_in.codeword_out = cw;
      rsp_in.code_length  = in_s2.n;
      rsp_in.syndrome     = (in_s2.cmd == CMD_DECODE) ? in_s2.syn : '0;
      rsp_in.data_out     = gather_data(cw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

[rtl/hamming_sec_codec.sv]
// top level of the hamming single error correcting codec
//
// request channel: req_valid / req_stall / req_payload; cmd selects encode of
// data_in (low k bits) or check and correct of codeword_in (low n bits)
// result channel: rsp_valid / rsp_stall / rsp_payload, one result per request
// csr_we / csr_wdata write data_bits (k); 0 acts as 1, above 57 acts as 57;
// write it only while no request is in flight
//
// three register stages: placement and masking, parity trees, then parity
// insert or single bit correction with data extraction into the result register
// latency: a request taken at one edge raises rsp_valid after the second edge
// that follows, so its result can be taken at the third edge
// throughput: one request per cycle, the stages are fully pipelined
// a stalled result holds its payload; stages behind it keep filling bubbles,
// and req_stall rises only once all three stages hold requests and the result
// is stalled
// reset clears all stage valid bits and sets data_bits to 4
module hamming_sec_codec
   import hsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata
);

   logic [LEN_W-1:0] data_bits_ff;
   logic             s1_valid;
   logic             s2_valid;
   logic             s3_valid;
   s1_type           s1;
   s2_type           s2;
   logic             adv1;
   logic             adv2;
   logic             adv3;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= LEN_W'(4);
      end else if (csr_we) begin
         data_bits_ff <= csr_wdata;
      end
   end

   // a stage loads when it is empty or its content moves on
   assign adv3      = !s3_valid || !rsp_stall;
   assign adv2      = !s2_valid || adv3;
   assign adv1      = !s1_valid || adv2;
   assign req_stall = !adv1;

   hsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv1),
      .in_valid  (req_valid),
      .in_req    (req_payload),
      .data_bits (data_bits_ff),
      .out_valid (s1_valid),
      .out_s1    (s1)
   );

   hsc_syndrome u_syndrome (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv2),
      .in_valid  (s1_valid),
      .in_s1     (s1),
      .out_valid (s2_valid),
      .out_s2    (s2)
   );

   hsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv3),
      .in_valid  (s2_valid),
      .in_s2     (s2),
      .out_valid (s3_valid),
      .out_rsp   (rsp_payload)
   );

   assign rsp_valid = s3_valid;

endmodule

[rtl/hsc_checker.sv]
// port level checks of the codec and their binding
`include "hamming_sec_codec_macros.svh"

module hsc_prop_checker
   import hsc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   `HSC_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload)),
      "stalled result changed")
   `HSC_ASSERT(a_latency, clock, reset,
      (req_valid && !req_stall |-> ##3 rsp_valid),
      "no result three cycles after request")
   `HSC_ASSERT_RSP(a_status_code, clock, reset, rsp_valid,
      (rsp_payload.status != 2'd3), "unused status code")
   `HSC_ASSERT_RSP(a_ok_zero_syn, clock, reset, rsp_valid,
      ((rsp_payload.syndrome == '0) == (rsp_payload.status == STATUS_OK)),
      "status and syndrome disagree")
   `HSC_ASSERT_RSP(a_syn_range, clock, reset, rsp_valid,
      ((rsp_payload.status == STATUS_CORRECTED &&
        rsp_payload.syndrome <= rsp_payload.code_length) ||
       (rsp_payload.status == STATUS_RANGE &&
        rsp_payload.syndrome > rsp_payload.code_length) ||
       rsp_payload.status == STATUS_OK),
      "syndrome range and status disagree")

endmodule

bind hamming_sec_codec hsc_prop_checker u_hsc_prop_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
